>>> sv/f32rem_pkg.sv
// ----------------------------------------------------------------------------
// f32rem_pkg
// Shared constants and types for the binary32 remainder unit.
// ----------------------------------------------------------------------------
package f32rem_pkg;
	localparam logic [31:0] ExpMask    = 32'h7f80_0000;
	localparam logic [31:0] FracMask   = 32'h007f_ffff;
	localparam logic [31:0] QuietBit   = 32'h0040_0000;
	localparam logic [31:0] DefaultNan = 32'h7fc0_0000;
	localparam logic [31:0] SignMask   = 32'h8000_0000;
	localparam logic [31:0] AbsMask    = 32'h7fff_ffff;
	localparam int unsigned SigW = 24;
	localparam int unsigned ExpW = 10;
	localparam logic signed [ExpW-1:0] ExpBias = 10'sd127;
	localparam logic signed [ExpW-1:0] ExpMin  = -10'sd126;

	typedef logic [SigW-1:0] sig_t;
	typedef logic signed [ExpW-1:0] exp_t;

	typedef struct packed {
		logic start;
		sig_t xs;
		exp_t xe;
		sig_t ys;
		exp_t ye;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic [31:0] mag;
	} dp_rsp_t;
endpackage

>>> sv/float32_remainder_unit.sv
// ----------------------------------------------------------------------------
// float32_remainder_unit
// Exact truncated remainder (fmod) of two IEEE binary32 values.
// ----------------------------------------------------------------------------
// Usage: present dividend_bits and divisor_bits with in_valid; the request is
// taken when in_valid and in_ready are both high. One remainder_bits result
// follows on out_valid/out_ready for every request.
// Special operands (NaN, infinity, zero divisor, |x| <= |y|) present their
// result on out_valid the cycle after acceptance. Otherwise a shared
// compare/subtract-shift datapath performs one step per cycle: exponent
// difference plus one steps, then normalizing shifts and denormalizing
// shifts. The datapath handles one request at a time; in_ready is low from
// acceptance until the result is taken from the output register, and
// returns high the cycle after. A stalled receiver holds out_valid and the
// result steady. Reset (arst_n low) empties the unit with no result
// pending.
// ----------------------------------------------------------------------------
module float32_remainder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] dividend_bits,
	input  logic [31:0] divisor_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] remainder_bits
);
	import f32rem_pkg::*;

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StBusy = 2'd1;
	localparam logic [1:0] StOut  = 2'd2;

	logic [1:0] state_q;
	logic [31:0] res_q;
	logic [31:0] sign_q;
	dp_cmd_t cmd;
	dp_rsp_t rsp;

	logic [31:0] x, y, spec;
	logic is_spec;
	sig_t xs, ys;
	exp_t xe, ye;

	function automatic sig_t norm_sig(input logic [31:0] m);
		sig_t s;
		s = sig_t'(m & FracMask);
		if (m[30:23] != 8'd0) return s | sig_t'(24'h80_0000);
		for (int i = 0; i < 23; i++) if (!s[SigW-1]) s = {s[SigW-2:0], 1'b0};
		return s;
	endfunction

	function automatic exp_t norm_exp(input logic [31:0] m);
		exp_t e;
		logic [4:0] lz;
		logic found;
		if (m[30:23] != 8'd0) return exp_t'({2'b00, m[30:23]}) - ExpBias;
		lz = '0;
		found = 1'b0;
		for (int i = 22; i >= 0; i--) begin
			if (!found && m[i]) found = 1'b1;
			else if (!found) lz = lz + 5'd1;
		end
		e = ExpMin - exp_t'({5'b0, lz}) - exp_t'(1);
		return e;
	endfunction

	assign x = dividend_bits & AbsMask;
	assign y = divisor_bits & AbsMask;
	assign xs = norm_sig(x);
	assign ys = norm_sig(y);
	assign xe = norm_exp(x);
	assign ye = norm_exp(y);

	always_comb begin
		is_spec = 1'b1;
		spec = '0;
		priority if (x > ExpMask) spec = dividend_bits | QuietBit;
		else if (y > ExpMask) spec = divisor_bits | QuietBit;
		else if (x == ExpMask || y == '0) spec = DefaultNan;
		else if (y == ExpMask || x < y) spec = dividend_bits;
		else if (x == y) spec = dividend_bits & SignMask;
		else is_spec = 1'b0;
	end

	assign in_ready = state_q == StIdle;
	assign cmd.start = in_valid && in_ready && !is_spec;
	assign cmd.xs = xs;
	assign cmd.xe = xe;
	assign cmd.ys = ys;
	assign cmd.ye = ye;

	f32rem_core u_core (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			unique case (state_q)
				StIdle: if (in_valid) state_q <= is_spec ? StOut : StBusy;
				StBusy: if (rsp.done) state_q <= StOut;
				StOut: if (out_ready) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == StIdle && in_valid) begin
			res_q  <= spec;
			sign_q <= dividend_bits & SignMask;
		end else if (state_q == StBusy && rsp.done) begin
			res_q <= sign_q | rsp.mag;
		end
	end

	assign out_valid = state_q == StOut;
	assign remainder_bits = res_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(remainder_bits)))
		else $error("result dropped");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == StBusy) else $error("stray done");
endmodule

>>> sv/f32rem_core.sv
// ----------------------------------------------------------------------------
// f32rem_core
// Iterative shift-subtract datapath: one compare/subtract or shift per cycle.
// ----------------------------------------------------------------------------
module f32rem_core (
	input  logic                clk,
	input  logic                arst_n,
	input  f32rem_pkg::dp_cmd_t cmd,
	output f32rem_pkg::dp_rsp_t rsp
);
	import f32rem_pkg::*;

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StLoop = 3'd1;
	localparam logic [2:0] StNorm = 3'd2;
	localparam logic [2:0] StSub  = 3'd3;
	localparam logic [2:0] StDone = 3'd4;

	logic [2:0] state_q;
	logic [SigW:0] xs_q;
	sig_t ys_q;
	exp_t xe_q, ye_q;
	logic [31:0] mag_q;

	logic ge;
	sig_t diff;
	assign ge   = xs_q >= {1'b0, ys_q};
	assign diff = ge ? sig_t'(xs_q - {1'b0, ys_q}) : xs_q[SigW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			unique case (state_q)
				StIdle: if (cmd.start) state_q <= StLoop;
				StLoop: begin
					if (diff == '0) state_q <= StDone;
					else if (!(xe_q > ye_q)) state_q <= StNorm;
				end
				StNorm: if (xs_q[SigW-1]) state_q <= StSub;
				StSub: if (xe_q >= ExpMin || xs_q == '0) state_q <= StDone;
				StDone: state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			StIdle: begin
				xs_q  <= {1'b0, cmd.xs};
				xe_q  <= cmd.xe;
				ys_q  <= cmd.ys;
				ye_q  <= cmd.ye;
				mag_q <= '0;
			end
			StLoop: begin
				if (diff == '0) begin
					mag_q <= '0;
				end else if (xe_q > ye_q) begin
					xs_q <= {diff, 1'b0};
					xe_q <= xe_q - exp_t'(1);
				end else begin
					xs_q <= {1'b0, diff};
				end
			end
			StNorm: begin
				if (!xs_q[SigW-1]) begin
					xs_q <= {xs_q[SigW-1:0], 1'b0};
					xe_q <= xe_q - exp_t'(1);
				end else if (xe_q >= ExpMin) begin
					mag_q <= {1'b0, 8'(xe_q + ExpBias), xs_q[22:0]};
				end
			end
			StSub: begin
				if (xe_q >= ExpMin || xs_q == '0) begin
					if (xe_q < ExpMin || !xs_q[SigW-1]) mag_q <= 32'(xs_q);
				end else begin
					xs_q <= xs_q >> 1;
					xe_q <= xe_q + exp_t'(1);
				end
			end
			default: ;
		endcase
	end

	assign rsp.done = state_q == StDone;
	assign rsp.mag  = mag_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("done held");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StIdle && cmd.start) |=> state_q == StLoop) else $error("no start");
	a_norm_top: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StSub) |-> (xs_q[SigW-1] || xe_q <= ExpMin))
		else $error("unnormalized");
endmodule
